// ===== sv/ctw_pkg.sv =====
// ----------------------------------------------------------------------------
// ctw_pkg
// shared constants, codes and controller/datapath interface types for the
// text console writer
// ----------------------------------------------------------------------------
`default_nettype none

package ctw_pkg;

  // screen geometry
  localparam int unsigned COLUMNS      = 80;
  localparam int unsigned ROWS         = 25;
  localparam int unsigned CELLS        = ROWS * COLUMNS;
  localparam int unsigned SCROLL_CELLS = (ROWS - 1) * COLUMNS;

  // field widths
  localparam int unsigned ADDR_W    = $clog2(CELLS);
  localparam int unsigned ROW_W     = 5;
  localparam int unsigned COL_W     = 7;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned COLOR_W   = 4;
  localparam int unsigned CELL_W    = 2 * COLOR_W + CHAR_W;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned CFG_IDX_W = 1;

  typedef logic [ADDR_W-1:0] addr_t;

  // request commands
  typedef enum logic [CMD_W-1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FG = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BG = 1'd1;

  localparam logic [COLOR_W-1:0] FG_RESET = 4'd7;
  localparam logic [COLOR_W-1:0] BG_RESET = 4'd0;

  localparam logic [CHAR_W-1:0] NL_CODE    = 8'h0A;
  localparam logic [CHAR_W-1:0] BLANK_CODE = 8'h20;

  // memory address source
  typedef enum logic [1:0] {
    ASEL_CURSOR = 2'd0,
    ASEL_COUNT  = 2'd1,
    ASEL_SRC    = 2'd2,
    ASEL_READ   = 2'd3
  } asel_e;

  // memory write data source
  typedef enum logic [1:0] {
    WSEL_ZERO  = 2'd0,
    WSEL_CHAR  = 2'd1,
    WSEL_BLANK = 2'd2,
    WSEL_MOVE  = 2'd3
  } wsel_e;

  // cursor update
  typedef enum logic [2:0] {
    CUR_HOLD    = 3'd0,
    CUR_ADV     = 3'd1,
    CUR_NEWLINE = 3'd2,
    CUR_HOME    = 3'd3,
    CUR_BOTTOM  = 3'd4
  } cur_e;

  // controller -> datapath
  typedef struct packed {
    logic  accept;
    logic  mem_we;
    logic  mem_re;
    asel_e asel;
    wsel_e wsel;
    logic  cnt_clr;
    logic  cnt_inc;
    cur_e  cur_op;
    logic  out_load;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    cmd_e cmd;
    logic is_nl;
    logic last_col;
    logic last_row;
    logic read_ok;
    logic cnt_scr_last;
    logic cnt_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== sv/ctw_ctrl.sv =====
// ----------------------------------------------------------------------------
// ctw_ctrl
// sequencer for the text console: clearing pass, put, scroll, clear, read
// ----------------------------------------------------------------------------
`default_nettype none

module ctw_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  ctw_pkg::sts_t      sts_i,
  output ctw_pkg::ctl_t      ctl_o
);

  typedef enum logic [9:0] {
    ST_CLR    = 10'b0000000001,
    ST_IDLE   = 10'b0000000010,
    ST_DECODE = 10'b0000000100,
    ST_PUT    = 10'b0000001000,
    ST_SCR_RD = 10'b0000010000,
    ST_SCR_WR = 10'b0000100000,
    ST_BLANK  = 10'b0001000000,
    ST_CLS    = 10'b0010000000,
    ST_READ   = 10'b0100000000,
    ST_DONE   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d        = state_q;
    ctl_o          = '0;
    ctl_o.asel     = ctw_pkg::ASEL_CURSOR;
    ctl_o.wsel     = ctw_pkg::WSEL_ZERO;
    ctl_o.cur_op   = ctw_pkg::CUR_HOLD;
    case (state_q)
      ST_CLR: begin
        ctl_o.mem_we  = 1'b1;
        ctl_o.asel    = ctw_pkg::ASEL_COUNT;
        ctl_o.wsel    = ctw_pkg::WSEL_ZERO;
        ctl_o.cnt_inc = 1'b1;
        if (sts_i.cnt_last) begin
          ctl_o.cnt_inc = 1'b0;
          ctl_o.cnt_clr = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          ctl_o.accept = 1'b1;
          state_d      = ST_DECODE;
        end
      end
      ST_DECODE: begin
        ctl_o.cnt_clr = 1'b1;
        case (sts_i.cmd)
          ctw_pkg::CMD_PUT: begin
            if (!sts_i.is_nl) begin
              state_d = ST_PUT;
            end else if (sts_i.last_row) begin
              state_d = ST_SCR_RD;
            end else begin
              ctl_o.cur_op = ctw_pkg::CUR_NEWLINE;
              state_d      = ST_DONE;
            end
          end
          ctw_pkg::CMD_CLEAR: state_d = ST_CLS;
          ctw_pkg::CMD_READ:  state_d = sts_i.read_ok ? ST_READ : ST_DONE;
          default:            state_d = ST_DONE;
        endcase
      end
      ST_PUT: begin
        ctl_o.mem_we = 1'b1;
        ctl_o.asel   = ctw_pkg::ASEL_CURSOR;
        ctl_o.wsel   = ctw_pkg::WSEL_CHAR;
        if (!sts_i.last_col) begin
          ctl_o.cur_op = ctw_pkg::CUR_ADV;
          state_d      = ST_DONE;
        end else if (sts_i.last_row) begin
          state_d = ST_SCR_RD;
        end else begin
          ctl_o.cur_op = ctw_pkg::CUR_NEWLINE;
          state_d      = ST_DONE;
        end
      end
      ST_SCR_RD: begin
        ctl_o.mem_re = 1'b1;
        ctl_o.asel   = ctw_pkg::ASEL_SRC;
        state_d      = ST_SCR_WR;
      end
      ST_SCR_WR: begin
        ctl_o.mem_we  = 1'b1;
        ctl_o.asel    = ctw_pkg::ASEL_COUNT;
        ctl_o.wsel    = ctw_pkg::WSEL_MOVE;
        ctl_o.cnt_inc = 1'b1;
        state_d       = sts_i.cnt_scr_last ? ST_BLANK : ST_SCR_RD;
      end
      ST_BLANK: begin
        ctl_o.mem_we  = 1'b1;
        ctl_o.asel    = ctw_pkg::ASEL_COUNT;
        ctl_o.wsel    = ctw_pkg::WSEL_BLANK;
        ctl_o.cnt_inc = 1'b1;
        if (sts_i.cnt_last) begin
          ctl_o.cur_op = ctw_pkg::CUR_BOTTOM;
          state_d      = ST_DONE;
        end
      end
      ST_CLS: begin
        ctl_o.mem_we  = 1'b1;
        ctl_o.asel    = ctw_pkg::ASEL_COUNT;
        ctl_o.wsel    = ctw_pkg::WSEL_BLANK;
        ctl_o.cnt_inc = 1'b1;
        if (sts_i.cnt_last) begin
          ctl_o.cur_op = ctw_pkg::CUR_HOME;
          state_d      = ST_DONE;
        end
      end
      ST_READ: begin
        ctl_o.mem_re = 1'b1;
        ctl_o.asel   = ctw_pkg::ASEL_READ;
        state_d      = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          ctl_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/ctw_dpath.sv =====
// ----------------------------------------------------------------------------
// ctw_dpath
// cell store, cursor, sweep counter, color registers and result register
// ----------------------------------------------------------------------------
`default_nettype none

module ctw_dpath (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  ctw_pkg::ctl_t                          ctl_i,
  output ctw_pkg::sts_t                          sts_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [ctw_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [ctw_pkg::COLOR_W-1:0]       cfg_data_i,
  input  wire logic [ctw_pkg::CMD_W-1:0]         command_i,
  input  wire logic [ctw_pkg::CHAR_W-1:0]        char_code_i,
  input  wire logic [ctw_pkg::ROW_W-1:0]         read_row_i,
  input  wire logic [ctw_pkg::COL_W-1:0]         read_col_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [ctw_pkg::ROW_W-1:0]              cursor_row_out_o,
  output logic [ctw_pkg::COL_W-1:0]              cursor_col_out_o,
  output logic [ctw_pkg::CELL_W-1:0]             cell_value_o,
  output logic                                   did_scroll_o
);

  logic [ctw_pkg::CELL_W-1:0]  mem_q [ctw_pkg::CELLS];
  logic [ctw_pkg::CELL_W-1:0]  rd_q;

  logic [ctw_pkg::COLOR_W-1:0] fg_q, bg_q;
  logic [ctw_pkg::ROW_W-1:0]   row_q, row_d;
  logic [ctw_pkg::COL_W-1:0]   col_q, col_d;
  ctw_pkg::addr_t              cnt_q, cnt_d;
  logic                        scroll_q, scroll_d;

  // latched request
  ctw_pkg::cmd_e               cmd_q;
  logic [ctw_pkg::CHAR_W-1:0]  char_q;
  logic [ctw_pkg::ROW_W-1:0]   rrow_q;
  logic [ctw_pkg::COL_W-1:0]   rcol_q;

  // result register
  logic                        out_valid_q;
  logic [ctw_pkg::ROW_W-1:0]   out_row_q;
  logic [ctw_pkg::COL_W-1:0]   out_col_q;
  logic [ctw_pkg::CELL_W-1:0]  out_cell_q;
  logic                        out_scroll_q;

  ctw_pkg::addr_t              cur_addr, rd_addr, src_addr, mem_addr;
  logic [ctw_pkg::CELL_W-1:0]  wdata;
  logic                        read_ok;

  assign cur_addr = ctw_pkg::ADDR_W'(row_q) * ctw_pkg::ADDR_W'(ctw_pkg::COLUMNS)
                  + ctw_pkg::ADDR_W'(col_q);
  assign rd_addr  = ctw_pkg::ADDR_W'(rrow_q) * ctw_pkg::ADDR_W'(ctw_pkg::COLUMNS)
                  + ctw_pkg::ADDR_W'(rcol_q);
  assign src_addr = cnt_q + ctw_pkg::ADDR_W'(ctw_pkg::COLUMNS);
  assign read_ok  = (rrow_q < ctw_pkg::ROW_W'(ctw_pkg::ROWS))
                 && (rcol_q < ctw_pkg::COL_W'(ctw_pkg::COLUMNS));

  always_comb begin
    case (ctl_i.asel)
      ctw_pkg::ASEL_CURSOR: mem_addr = cur_addr;
      ctw_pkg::ASEL_COUNT:  mem_addr = cnt_q;
      ctw_pkg::ASEL_SRC:    mem_addr = src_addr;
      ctw_pkg::ASEL_READ:   mem_addr = rd_addr;
      default:              mem_addr = cnt_q;
    endcase
  end

  always_comb begin
    case (ctl_i.wsel)
      ctw_pkg::WSEL_ZERO:  wdata = '0;
      ctw_pkg::WSEL_CHAR:  wdata = {bg_q, fg_q, char_q};
      ctw_pkg::WSEL_BLANK: wdata = {bg_q, fg_q, ctw_pkg::BLANK_CODE};
      ctw_pkg::WSEL_MOVE:  wdata = rd_q;
      default:             wdata = '0;
    endcase
  end

  // single-port cell store, registered read
  always_ff @(posedge clk_i) begin
    if (ctl_i.mem_we) begin
      mem_q[mem_addr] <= wdata;
    end
    if (ctl_i.mem_re) begin
      rd_q <= mem_q[mem_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q <= ctw_pkg::FG_RESET;
      bg_q <= ctw_pkg::BG_RESET;
    end else if (cfg_we_i) begin
      if (cfg_index_i == ctw_pkg::CFG_FG) begin
        fg_q <= cfg_data_i;
      end
      if (cfg_index_i == ctw_pkg::CFG_BG) begin
        bg_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      cmd_q  <= ctw_pkg::cmd_e'(command_i);
      char_q <= char_code_i;
      rrow_q <= read_row_i;
      rcol_q <= read_col_i;
    end
  end

  always_comb begin
    row_d    = row_q;
    col_d    = col_q;
    scroll_d = ctl_i.accept ? 1'b0 : scroll_q;
    case (ctl_i.cur_op)
      ctw_pkg::CUR_HOLD: ;
      ctw_pkg::CUR_ADV:  col_d = col_q + 1'b1;
      ctw_pkg::CUR_NEWLINE: begin
        col_d = '0;
        row_d = row_q + 1'b1;
      end
      ctw_pkg::CUR_HOME: begin
        col_d = '0;
        row_d = '0;
      end
      ctw_pkg::CUR_BOTTOM: begin
        col_d    = '0;
        row_d    = ctw_pkg::ROW_W'(ctw_pkg::ROWS - 1);
        scroll_d = 1'b1;
      end
      default: ;
    endcase
    if (ctl_i.cnt_clr) begin
      cnt_d = '0;
    end else if (ctl_i.cnt_inc) begin
      cnt_d = cnt_q + 1'b1;
    end else begin
      cnt_d = cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q    <= '0;
      col_q    <= '0;
      cnt_q    <= '0;
      scroll_q <= 1'b0;
    end else begin
      row_q    <= row_d;
      col_q    <= col_d;
      cnt_q    <= cnt_d;
      scroll_q <= scroll_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.out_load) begin
      out_row_q    <= row_q;
      out_col_q    <= col_q;
      out_scroll_q <= scroll_q;
      out_cell_q   <= (cmd_q == ctw_pkg::CMD_READ && read_ok) ? rd_q : '0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign cursor_row_out_o = out_row_q;
  assign cursor_col_out_o = out_col_q;
  assign cell_value_o     = out_cell_q;
  assign did_scroll_o     = out_scroll_q;

  assign sts_o.cmd          = cmd_q;
  assign sts_o.is_nl        = (char_q == ctw_pkg::NL_CODE);
  assign sts_o.last_col     = (col_q == ctw_pkg::COL_W'(ctw_pkg::COLUMNS - 1));
  assign sts_o.last_row     = (row_q == ctw_pkg::ROW_W'(ctw_pkg::ROWS - 1));
  assign sts_o.read_ok      = read_ok;
  assign sts_o.cnt_scr_last = (cnt_q == ctw_pkg::ADDR_W'(ctw_pkg::SCROLL_CELLS - 1));
  assign sts_o.cnt_last     = (cnt_q == ctw_pkg::ADDR_W'(ctw_pkg::CELLS - 1));
  assign sts_o.out_free     = !out_valid_q || !out_stall_i;

endmodule

`default_nettype wire

// ===== sv/text_console_writer.sv =====
// ----------------------------------------------------------------------------
// text_console_writer
// 80x25 text-mode console: cell store with cursor, scroll, clear and read
// ----------------------------------------------------------------------------
// usage:
//   request channel (in_valid_i / in_stall_o) carries command, character and
//   read position; a request is taken when in_valid_i is high and in_stall_o
//   is low. result channel (out_valid_o / out_stall_i) returns one result per
//   request: cursor after the request, the read cell (zero otherwise) and a
//   scroll flag.
//   colors are written through cfg_we_i / cfg_index_i / cfg_data_i while no
//   request is in flight; index 0 is foreground, index 1 is background.
//   one request is worked at a time; all cell traffic goes through the single
//   port of the cell store, so the states from accept to result are:
//     put (wrap without scroll included): decode, cell write, done
//     newline without scroll, unused command, read out of range: decode, done
//     read in range: decode, cell read, done; clear screen: decode, blank
//     2000 cells (one cell per cycle), done; scroll: as wrap or newline, then
//     read and write per moved cell (1920 cells), blank row (80 cells), done
//   the next request can be taken in the cycle after a result is loaded.
//   after reset all 2000 cells of the store are cleared to zero in a pass
//   during which no request is taken; cursor and colors reset at once.
//   if the receiver stalls, a finished result waits in the output register
//   and the next result is held back in done until that register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration writes
  input  wire logic                          cfg_we_i,
  input  wire logic [ctw_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [ctw_pkg::COLOR_W-1:0]   cfg_data_i,
  // request channel
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [ctw_pkg::CMD_W-1:0]     command_i,
  input  wire logic [ctw_pkg::CHAR_W-1:0]    char_code_i,
  input  wire logic [ctw_pkg::ROW_W-1:0]     read_row_i,
  input  wire logic [ctw_pkg::COL_W-1:0]     read_col_i,
  // result channel
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [ctw_pkg::ROW_W-1:0]          cursor_row_out_o,
  output logic [ctw_pkg::COL_W-1:0]          cursor_col_out_o,
  output logic [ctw_pkg::CELL_W-1:0]         cell_value_o,
  output logic                               did_scroll_o
);

  // command and status between sequencer and datapath
  ctw_pkg::ctl_t ctl;
  ctw_pkg::sts_t sts;

  // sequencer: clearing pass, request decode, scroll and clear sweeps
  ctw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  // cell store, cursor, colors and result register
  ctw_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctl_i            (ctl),
    .sts_o            (sts),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .command_i        (command_i),
    .char_code_i      (char_code_i),
    .read_row_i       (read_row_i),
    .read_col_i       (read_col_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .cursor_row_out_o (cursor_row_out_o),
    .cursor_col_out_o (cursor_col_out_o),
    .cell_value_o     (cell_value_o),
    .did_scroll_o     (did_scroll_o)
  );

endmodule

`default_nettype wire
